FILE: rtl/pcmrb_pkg.sv
// shared constants, codes and types for the pcm ring buffer mixer
`timescale 1ns / 1ps
package pcmrb_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int MAX_BLOCK  = 1024;
  localparam int BLK_W      = $clog2(MAX_BLOCK + 1);
  localparam int FRAC_BITS  = 28;
  localparam int MIX_LIMIT  = 32766;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_REQUEST = 2'd1;
  localparam logic [1:0] REQ_MIX     = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_DATA  = 2'd2;

  typedef enum logic [0:0] {
    S_IDLE,
    S_MIX
  } ctrl_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       accept;      // a word is taken this cycle
    logic [1:0] req;         // request code of the word taken
    logic       load_out;    // load the result register
    logic       mix_finish;  // result comes from the registered ring read
  } dp_cmd_t;

endpackage

FILE: rtl/pcmrb_ctrl.sv
// controller: input and output handshake and the mix read sequencing
`timescale 1ns / 1ps
module pcmrb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  output logic               out_valid,
  input  logic               out_ready,
  output pcmrb_pkg::dp_cmd_t cmd
);
  import pcmrb_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.req        = req_type;
    cmd.load_out   = 1'b0;
    cmd.mix_finish = 1'b0;
    case (state)
      S_IDLE: begin
        // result register must be free or emptying this cycle
        in_ready   = !out_valid || out_ready;
        cmd.accept = in_valid && in_ready;
        if (cmd.accept) begin
          if (req_type == REQ_MIX) begin
            state_next = S_MIX;
          end else begin
            cmd.load_out = 1'b1;
          end
        end
      end
      S_MIX: begin
        cmd.load_out   = 1'b1;
        cmd.mix_finish = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

FILE: rtl/pcmrb_dp.sv
// datapath: sample ring, pointers, block reservation and saturating mix
`timescale 1ns / 1ps
module pcmrb_dp (
  input  logic                clk,
  input  logic                rst,
  input  pcmrb_pkg::dp_cmd_t  cmd,
  input  logic signed [31:0]  sample_left,
  input  logic signed [31:0]  sample_right,
  input  logic                stereo,
  input  logic [10:0]         block_len,
  input  logic signed [15:0]  dst_slot0,
  input  logic signed [15:0]  dst_slot1,
  output logic [1:0]          status,
  output logic signed [15:0]  out_slot0,
  output logic signed [15:0]  out_slot1
);
  import pcmrb_pkg::*;

  localparam logic signed [33:0] Q_ONE = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] Q_RND = 34'sd1 <<< (FRAC_BITS - 16);
  localparam logic signed [16:0] M_HI  = 17'(MIX_LIMIT);
  localparam logic signed [16:0] M_LO  = -17'(MIX_LIMIT);

  function automatic logic [15:0] quantize(input logic signed [31:0] raw);
    logic signed [33:0] s;
    logic signed [33:0] q;
    s = 34'(raw) + Q_RND;
    if (s >= Q_ONE) begin
      s = Q_ONE - 34'sd1;
    end else if (s < -Q_ONE) begin
      s = -Q_ONE;
    end
    q = s >>> (FRAC_BITS - 15);
    return q[15:0];
  endfunction

  function automatic logic [15:0] mix_slot(input logic signed [15:0] a,
                                            input logic signed [15:0] d);
    logic signed [16:0] w;
    w = 17'(a) + 17'(d);
    if (w > M_HI) begin
      w = M_HI;
    end else if (w < M_LO) begin
      w = M_LO;
    end
    return w[15:0];
  endfunction

  logic [31:0]      ring [RING_DEPTH];
  logic [31:0]      rd_data;
  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] read_pointer;
  logic [BLK_W-1:0] block_remaining;
  logic [PTR_W-1:0] count;
  logic             full;
  logic [BLK_W-1:0] len;
  logic             grant_ok;
  logic             mix_ok;
  logic             mix_grant;
  logic signed [15:0] dst0;
  logic signed [15:0] dst1;
  logic [15:0]      q_left;
  logic [15:0]      q_slot0;
  logic             wr_en;

  assign count    = write_pointer - read_pointer;
  assign full     = (count == PTR_W'(RING_DEPTH - 1));
  assign len      = (32'(block_len) > 32'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK)
                                                     : BLK_W'(block_len);
  assign grant_ok = (32'(count) >= 32'(len));
  assign mix_ok   = (block_remaining != '0) && (count != '0);
  assign q_left   = quantize(sample_left);
  assign q_slot0  = stereo ? quantize(sample_right) : q_left;
  assign wr_en    = cmd.accept && (cmd.req == REQ_WRITE) && !full;

  // ring memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[write_pointer] <= {q_left, q_slot0};
    end
    rd_data <= ring[read_pointer];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer   <= '0;
      read_pointer    <= '0;
      block_remaining <= '0;
    end else if (cmd.accept) begin
      case (cmd.req)
        REQ_WRITE: begin
          if (!full) begin
            write_pointer <= write_pointer + PTR_W'(1);
          end
        end
        REQ_REQUEST: begin
          block_remaining <= grant_ok ? len : '0;
        end
        REQ_MIX: begin
          if (mix_ok) begin
            read_pointer    <= read_pointer + PTR_W'(1);
            block_remaining <= block_remaining - BLK_W'(1);
          end else begin
            block_remaining <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // mix operands held for the read cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mix_grant <= mix_ok;
      dst0      <= dst_slot0;
      dst1      <= dst_slot1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.mix_finish) begin
        if (mix_grant) begin
          status    <= ST_OK;
          out_slot0 <= mix_slot(rd_data[15:0], dst0);
          out_slot1 <= mix_slot(rd_data[31:16], dst1);
        end else begin
          status    <= ST_NO_DATA;
          out_slot0 <= dst0;
          out_slot1 <= dst1;
        end
      end else begin
        out_slot0 <= '0;
        out_slot1 <= '0;
        case (cmd.req)
          REQ_WRITE:   status <= full ? ST_FULL : ST_OK;
          REQ_REQUEST: status <= grant_ok ? ST_OK : ST_NO_DATA;
          default:     status <= ST_OK;
        endcase
      end
    end
  end

endmodule

FILE: rtl/pcm_ring_buffer_saturating_mixer.sv
// top level of the stereo pcm ring buffer with saturating mix-out
`timescale 1ns / 1ps
// Stereo pcm ring fifo of 4096 pair entries (4095 usable). A write word
// (req_type 0) rounds and clips two decoder samples with 28 fraction bits to
// 16 bits and stores them, right in slot 0 and left in slot 1 (left in both
// when mono); a full ring refuses it with status 1. A request word
// (req_type 1) reserves block_len pairs, limited to 1024, if that many are
// stored, otherwise status 2. Each mix word (req_type 2) pops one reserved
// pair and adds it to dst_slot0/dst_slot1, saturating at +/-32766; with
// nothing reserved the destination pair passes through with status 2.
// Timing: write and request words give their result in the cycle after they
// are taken, and a new word can be taken every cycle while the receiver keeps
// taking results; a mix word holds off the next word, as the pair is fetched
// through the registered read port of the ring memory before the add. The
// result register lets a new word be taken in the cycle its predecessor's
// result is taken. No clearing pass is run after reset.
module pcm_ring_buffer_saturating_mixer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] sample_left,
  input  logic signed [31:0] sample_right,
  input  logic               stereo,
  input  logic [10:0]        block_len,
  input  logic signed [15:0] dst_slot0,
  input  logic signed [15:0] dst_slot1,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [15:0] out_slot0,
  output logic signed [15:0] out_slot1
);
  import pcmrb_pkg::*;

  // command bundle from the sequencer to the datapath
  dp_cmd_t cmd;

  // handshake and mix sequencing
  pcmrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // ring memory, pointers, quantiser and mixer
  pcmrb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .stereo       (stereo),
    .block_len    (block_len),
    .dst_slot0    (dst_slot0),
    .dst_slot1    (dst_slot1),
    .status       (status),
    .out_slot0    (out_slot0),
    .out_slot1    (out_slot1)
  );

endmodule

FILE: verif/pcm_ring_buffer_saturating_mixer_tb.sv
// self-checking testbench for the pcm ring buffer with saturating mix-out
`timescale 1ns / 1ps
module pcm_ring_buffer_saturating_mixer_tb;
  import pcmrb_pkg::*;

  // request code the block does not use: answered with zeros, no change
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int HOLD_CYCLES = 200;   // long receiver hold-off
  localparam int DRAIN_LIMIT = 5000;  // cycles allowed for the tail to arrive
  localparam int TAIL_CYCLES = 8;     // settling after the last result

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] slot0;
    logic signed [15:0] slot1;
  } mix_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         req_type;
  logic signed [31:0] sample_left;
  logic signed [31:0] sample_right;
  logic               stereo;
  logic [10:0]        block_len;
  logic signed [15:0] dst_slot0;
  logic signed [15:0] dst_slot1;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic signed [15:0] out_slot0;
  logic signed [15:0] out_slot1;

  // private copy of the ring, its pointers and the open reservation
  logic [31:0]        pair_ring [RING_DEPTH];
  logic [PTR_W-1:0]   wr_idx;
  logic [PTR_W-1:0]   rd_idx;
  logic [BLK_W-1:0]   reserved_left;

  mix_result_t        results_due [$];
  mix_result_t        oldest;
  int                 errors;
  int                 words_sent;
  bit                 quiet;      // no idling on either side
  bit                 hold_req;   // asks the receiver for a long hold-off

  pcm_ring_buffer_saturating_mixer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .stereo       (stereo),
    .block_len    (block_len),
    .dst_slot0    (dst_slot0),
    .dst_slot1    (dst_slot1),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_slot0    (out_slot0),
    .out_slot1    (out_slot1)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // generous overall limit, well above the slowest legal run
  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  // pairs currently held in the ring, wraps with the pointers
  function automatic logic [PTR_W-1:0] pairs_held();
    return wr_idx - rd_idx;
  endfunction

  // round at bit 12, clip to one full scale, keep the top 16 bits
  function automatic logic signed [15:0] round_clip(input logic signed [31:0] raw);
    longint acc;
    longint one;
    one = longint'(1) <<< FRAC_BITS;
    acc = longint'(raw) + (longint'(1) <<< (FRAC_BITS - 16));
    if (acc >= one) begin
      acc = one - 1;
    end else if (acc < -one) begin
      acc = -one;
    end
    acc = acc >>> (FRAC_BITS - 15);
    return acc[15:0];
  endfunction

  // add with saturation to the symmetric mix limit
  function automatic logic signed [15:0] mix_sat(input logic signed [15:0] held,
                                                 input logic signed [15:0] dst);
    int sum;
    sum = int'(held) + int'(dst);
    if (sum > MIX_LIMIT) begin
      sum = MIX_LIMIT;
    end else if (sum < -MIX_LIMIT) begin
      sum = -MIX_LIMIT;
    end
    return sum[15:0];
  endfunction

  // step the private ring by one accepted word and queue its result
  task automatic advance_ring_model(input logic [1:0] req,
                                    input logic signed [31:0] left,
                                    input logic signed [31:0] right,
                                    input logic st,
                                    input logic [10:0] len,
                                    input logic signed [15:0] d0,
                                    input logic signed [15:0] d1);
    mix_result_t        r;
    logic signed [15:0] q_left;
    logic [10:0]        want_len;
    logic [31:0]        pair;
    r = '0;
    case (req)
      REQ_WRITE: begin
        // one entry is kept free so full and empty differ
        if (pairs_held() >= RING_DEPTH - 1) begin
          r.status = ST_FULL;
        end else begin
          q_left = round_clip(left);
          pair_ring[wr_idx] = {q_left, st ? round_clip(right) : q_left};
          wr_idx++;
        end
      end
      REQ_REQUEST: begin
        want_len = (len > MAX_BLOCK) ? 11'(MAX_BLOCK) : len;
        if (pairs_held() >= want_len) begin
          reserved_left = want_len;
        end else begin
          reserved_left = '0;
          r.status = ST_NO_DATA;
        end
      end
      REQ_MIX: begin
        if (reserved_left != 0 && pairs_held() != 0) begin
          pair = pair_ring[rd_idx];
          r.slot0 = mix_sat(pair[15:0], d0);
          r.slot1 = mix_sat(pair[31:16], d1);
          rd_idx++;
          reserved_left--;
        end else begin
          // no reservation: destination passes straight through
          reserved_left = '0;
          r.slot0 = d0;
          r.slot1 = d1;
          r.status = ST_NO_DATA;
        end
      end
      default: begin
      end
    endcase
    results_due.push_back(r);
  endtask

  // ---------------------------------------------------------------------
  // checking: every taken result against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d slot0 %0d slot1 %0d",
                 $time, status, out_slot0, out_slot1);
        errors++;
      end else begin
        oldest = results_due.pop_front();
        if (status !== oldest.status) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest.status, status);
          errors++;
        end
        if (out_slot0 !== oldest.slot0) begin
          $display("%0t: out_slot0 expected %0d actual %0d", $time, oldest.slot0,
                   out_slot0);
          errors++;
        end
        if (out_slot1 !== oldest.slot1) begin
          $display("%0t: out_slot1 expected %0d actual %0d", $time, oldest.slot1,
                   out_slot1);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: random stalls, a long hold-off on request, none when quiet
  // ---------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (hold_req) begin
        // long hold so the result path backs up and in_ready drops
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------

  // offer one word, hold it until taken, then predict its result
  task automatic send_word(input logic [1:0] req,
                           input logic signed [31:0] left,
                           input logic signed [31:0] right,
                           input logic st,
                           input logic [10:0] len,
                           input logic signed [15:0] d0,
                           input logic signed [15:0] d1);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    sample_left  <= left;
    sample_right <= right;
    stereo       <= st;
    block_len    <= len;
    dst_slot0    <= d0;
    dst_slot1    <= d1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    advance_ring_model(req, left, right, st, len, d0, d1);
  endtask

  // decoder samples: full range, inside full scale, or close to the clip points
  function automatic logic signed [31:0] rand_sample();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = $urandom;
      end
      1, 2: begin
        v = $signed(32'($urandom)) >>> 3;
      end
      default: begin
        v = ($urandom_range(0, 1) == 1) ? (32'sd1 <<< FRAC_BITS) : -(32'sd1 <<< FRAC_BITS);
        v = v + $signed(32'($urandom_range(0, 16383))) - 32'sd8192;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] rand_dst();
    logic signed [15:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // unused fields of each word carry random values
  task automatic write_pair(input logic signed [31:0] left, input logic signed [31:0] right,
                            input logic st);
    send_word(REQ_WRITE, left, right, st, 11'($urandom), rand_dst(), rand_dst());
  endtask

  task automatic request_block(input logic [10:0] len);
    send_word(REQ_REQUEST, $urandom, $urandom, 1'($urandom), len, rand_dst(), rand_dst());
  endtask

  task automatic mix_pair(input logic signed [15:0] d0, input logic signed [15:0] d1);
    send_word(REQ_MIX, $urandom, $urandom, 1'($urandom), 11'($urandom), d0, d1);
  endtask

  task automatic unused_word();
    send_word(REQ_UNUSED, $urandom, $urandom, 1'($urandom), 11'($urandom), rand_dst(),
              rand_dst());
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // empty ring: unknown code, mix with nothing reserved, short and zero requests
  task automatic test_empty_ring();
    unused_word();
    mix_pair(16'sh7FFF, 16'sh8000);
    request_block(11'd1);
    request_block(11'd0);
    mix_pair(16'sh8000, 16'sh7FFF);
  endtask

  // rounding and clipping at the edges of full scale, stereo and mono
  task automatic test_rounding_and_clip();
    write_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    write_pair((32'sd1 <<< FRAC_BITS) - 32'sd1, -(32'sd1 <<< FRAC_BITS), 1'b1);
    write_pair((32'sd1 <<< FRAC_BITS) - 32'sd4097, -(32'sd1 <<< FRAC_BITS) - 32'sd1, 1'b1);
    write_pair(32'sh1234_5678, 32'sh7FFF_FFFF, 1'b0);
    write_pair(-32'sd4097, 32'sd4096, 1'b1);
    write_pair(32'sd4095, -32'sd1, 1'b1);
  endtask

  // block grants, clamped length, saturation, replacement and overrun
  task automatic test_block_mixing();
    request_block(11'd2047);
    request_block(11'd6);
    mix_pair(16'sh8000, 16'sh7FFF);
    mix_pair(16'sh7FFF, 16'sh8000);
    unused_word();
    request_block(11'd2);
    mix_pair(16'sd0, 16'sd0);
    mix_pair(16'sd1, -16'sd1);
    mix_pair(16'sh7FFF, 16'sh7FFF);
    request_block(11'd2);
    mix_pair(16'sh8000, 16'sh8000);
    mix_pair(rand_dst(), rand_dst());
    mix_pair(rand_dst(), rand_dst());
  endtask

  // receiver holds off while words keep coming, so the input must stall
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) write_pair(rand_sample(), rand_sample(), 1'($urandom));
    request_block(11'd10);
    repeat (10) mix_pair(rand_dst(), rand_dst());
  endtask

  // mostly well-formed write bursts and reserved blocks, some noise
  task automatic test_random_traffic(input int count);
    int          stop_at;
    int          room;
    logic [10:0] len;
    int          mixes;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          repeat ($urandom_range(1, 12)) write_pair(rand_sample(), rand_sample(), 1'($urandom));
        end
        3, 4, 5: begin
          room = (pairs_held() > 16) ? 16 : int'(pairs_held());
          len = 11'($urandom_range(0, room));
          // now and then ask for more than is held
          if ($urandom_range(0, 7) == 0) len = 11'(int'(pairs_held()) + $urandom_range(1, 3));
          mixes = int'(len);
          if ($urandom_range(0, 3) == 0) mixes = mixes + 1;
          else if ($urandom_range(0, 5) == 0) mixes = $urandom_range(0, mixes);
          request_block(len);
          repeat (mixes) mix_pair(rand_dst(), rand_dst());
        end
        default: begin
          send_word(2'($urandom), $urandom, $urandom, 1'($urandom), 11'($urandom),
                    16'($urandom), 16'($urandom));
        end
      endcase
    end
  endtask

  // closing stretch with both sides always ready
  task automatic test_steady_stream();
    quiet = 1'b1;
    test_random_traffic(80);
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin
    int waited;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    req_type     <= REQ_WRITE;
    sample_left  <= '0;
    sample_right <= '0;
    stereo       <= 1'b0;
    block_len    <= '0;
    dst_slot0    <= '0;
    dst_slot1    <= '0;
    errors        = 0;
    words_sent    = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    wr_idx        = '0;
    rd_idx        = '0;
    reserved_left = '0;
    foreach (pair_ring[i]) pair_ring[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_ring();
    test_rounding_and_clip();
    test_block_mixing();
    test_backpressure();
    test_random_traffic(580);
    test_steady_stream();
    in_valid <= 1'b0;

    // let the last results drain, then a few settling cycles
    waited = 0;
    while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_due.size());
      errors++;
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pcmrb_pkg.sv
rtl/pcmrb_ctrl.sv
rtl/pcmrb_dp.sv
rtl/pcm_ring_buffer_saturating_mixer.sv
verif/pcm_ring_buffer_saturating_mixer_tb.sv
